[hw/rtl/pavs_pkg.sv]
// shared types, constants and tables of the additive voice synthesiser
package pavs_pkg;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2,
        OP_ALL_OFF  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_ATTACK  = 3'd1,
        ST_DECAY   = 3'd2,
        ST_SUSTAIN = 3'd3,
        ST_RELEASE = 3'd4
    } t_stage;

    typedef enum logic [3:0] {
        B_IDLE,
        B_SCAN,
        B_APPLY,
        B_ENV,
        B_GAIN,
        B_HARM,
        B_MUL,
        B_TERM,
        B_ROUND
    } t_bstate;

    localparam logic [2:0] CFG_ATTACK  = 3'd0;
    localparam logic [2:0] CFG_DECAY   = 3'd1;
    localparam logic [2:0] CFG_RELEASE = 3'd2;
    localparam logic [2:0] CFG_SUSTAIN = 3'd3;
    localparam logic [2:0] CFG_AMP     = 3'd4;

    localparam int LEVEL_W    = 24;
    localparam int AMP_W      = 16;
    localparam int NOTE_W     = 7;
    localparam int SAMPLE_W   = 16;
    localparam int HARM_COUNT = 5;
    localparam int ACC_W      = 35;
    localparam int GAIN_W     = 17;
    localparam int PROD_W     = 56;
    localparam int MIX_W      = 48;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = 24'd8388608;

    typedef struct packed {
        t_op               op;
        logic [NOTE_W-1:0] note;
    } t_item;

    typedef struct packed {
        logic [LEVEL_W-1:0] attack_step;
        logic [LEVEL_W-1:0] decay_step;
        logic [LEVEL_W-1:0] release_step;
        logic [LEVEL_W-1:0] hold_level;
        logic [AMP_W-1:0]   note_amplitude;
    } t_cfg;

    // harmonic weights in Q1.16
    function automatic logic [16:0] f_weight(input logic [2:0] h);
        logic [16:0] w;
        case (h)
            3'd0:    w = 17'd65536;
            3'd1:    w = 17'd32768;
            3'd2:    w = 17'd16384;
            3'd3:    w = 17'd8192;
            3'd4:    w = 17'd5243;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

    // octave from note 60 to 71 in Q16.16 hertz
    function automatic logic [31:0] f_octave_hz(input logic [3:0] k);
        logic [31:0] f;
        case (k)
            4'd0:    f = 32'd17145893;
            4'd1:    f = 32'd18165441;
            4'd2:    f = 32'd19245614;
            4'd3:    f = 32'd20390018;
            4'd4:    f = 32'd21602472;
            4'd5:    f = 32'd22887021;
            4'd6:    f = 32'd24247954;
            4'd7:    f = 32'd25689813;
            4'd8:    f = 32'd27217409;
            4'd9:    f = 32'd28835840;
            4'd10:   f = 32'd30550508;
            4'd11:   f = 32'd32367136;
            default: f = 32'd0;
        endcase
        return f;
    endfunction

endpackage

[hw/rtl/pavs_front.sv]
// front end: input acceptance, opcode decode and a two-entry command queue
module pavs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic [6:0]         i_note,
    output logic               o_q_valid,
    output pavs_pkg::t_item    o_q_item,
    input  logic               i_q_pop
);

    pavs_pkg::t_item r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            push;
    pavs_pkg::t_item item;

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    always_comb begin
        item.op   = pavs_pkg::t_op'(i_opcode);
        item.note = i_note;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, i_q_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[hw/rtl/pavs_back.sv]
// back end: voice table, envelope, harmonic sum, mix and output register
module pavs_back #(
    parameter int VOICE_COUNT     = 8,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_RATE_HZ  = 48000,
    parameter int PHASE_BITS      = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pavs_pkg::t_cfg       i_cfg,
    input  logic                 i_q_valid,
    input  pavs_pkg::t_item      i_q_item,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [15:0]          o_sample,
    output logic                 o_clipped
);

    localparam int VW         = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int SINE_SIZE  = 1 << SINE_TABLE_BITS;
    localparam int QUARTER    = SINE_SIZE >> 2;
    localparam int PITCH_SHL  = (PHASE_BITS >= 21) ? PHASE_BITS - 21 : 0;
    localparam longint PITCH_DEN =
        longint'(SAMPLE_RATE_HZ) << ((PHASE_BITS < 21) ? 21 - PHASE_BITS : 0);
    localparam logic [VW-1:0] LAST_V = VW'(VOICE_COUNT - 1);

    typedef logic signed [15:0] t_sine_rom [SINE_SIZE];
    typedef logic [PHASE_BITS-1:0] t_pitch_rom [128];

    function automatic logic [15:0] f_sin_quarter(input logic [63:0] m);
        logic [63:0] x, x2, term, sum, r;
        x    = (m * 64'd6746518852) >> SINE_TABLE_BITS;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
        term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
        r = (sum + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return r[15:0];
    endfunction

    function automatic t_sine_rom f_sine_rom();
        t_sine_rom   t;
        logic [63:0] quad, j, m;
        logic [15:0] v;
        for (int i = 0; i < SINE_SIZE; i++) begin
            quad = 64'(i) >> (SINE_TABLE_BITS - 2);
            j    = 64'(i) & 64'(QUARTER - 1);
            m    = quad[0] ? 64'(QUARTER) - j : j;
            v    = f_sin_quarter(m);
            t[i] = (quad >= 64'd2) ? -$signed(v) : $signed(v);
        end
        return t;
    endfunction

    function automatic t_pitch_rom f_pitch_rom();
        t_pitch_rom  t;
        logic [63:0] num;
        for (int i = 0; i < 128; i++) begin
            num  = 64'(pavs_pkg::f_octave_hz(4'(i % 12))) << (i / 12);
            num  = num << PITCH_SHL;
            num  = (num + 64'(PITCH_DEN / 2)) / PITCH_DEN;
            t[i] = num[PHASE_BITS-1:0];
        end
        return t;
    endfunction

    localparam t_sine_rom  SINE  = f_sine_rom();
    localparam t_pitch_rom PITCH = f_pitch_rom();

    // voice table
    logic [6:0]                     r_note   [VOICE_COUNT];
    logic                           r_active [VOICE_COUNT];
    pavs_pkg::t_stage               r_stage  [VOICE_COUNT];
    logic [pavs_pkg::LEVEL_W-1:0]   r_level  [VOICE_COUNT];
    logic [PHASE_BITS-1:0]          r_phase  [VOICE_COUNT];
    logic [PHASE_BITS-1:0]          r_inc    [VOICE_COUNT];

    pavs_pkg::t_bstate r_state, n_state;
    pavs_pkg::t_item   r_item;
    logic [VW-1:0]     r_v;
    logic              r_m_found, r_i_found, r_r_found;
    logic [VW-1:0]     r_m_idx, r_i_idx, r_r_idx;
    logic [2:0]        r_h;
    logic [PHASE_BITS-1:0]                r_hp;
    logic signed [15:0]                   r_sin;
    logic signed [pavs_pkg::ACC_W-1:0]    r_acc;
    logic [pavs_pkg::GAIN_W-1:0]          r_gain;
    logic signed [35:0]                   r_plo, r_phi;
    logic signed [pavs_pkg::MIX_W-1:0]    r_mix;
    logic              r_out_valid;
    logic [15:0]       r_out_sample;
    logic              r_out_clip;

    // voice under the sequencer
    logic [pavs_pkg::LEVEL_W-1:0] lv, nl, dec;
    logic [pavs_pkg::LEVEL_W:0]   att;
    pavs_pkg::t_stage             st, ns;
    logic                         act, na, skip, last_v;

    localparam int PROD_W_L = pavs_pkg::PROD_W;
    logic signed [PROD_W_L-1:0]   prod;
    logic signed [pavs_pkg::PROD_W-1:0] term;
    logic signed [63:0]           scaled;
    logic signed [31:0]           s;
    logic [15:0]                  sat;
    logic                         clip;
    logic                         out_free;
    logic [VW-1:0]                pick;

    assign lv     = r_level[r_v];
    assign st     = r_stage[r_v];
    assign act    = r_active[r_v];
    assign skip   = !act && (st == pavs_pkg::ST_IDLE);
    assign last_v = (r_v == LAST_V);
    assign att    = {1'b0, lv} + {1'b0, i_cfg.attack_step};
    assign dec    = (lv >= i_cfg.decay_step) ? lv - i_cfg.decay_step : '0;

    always_comb begin
        nl = lv;
        ns = st;
        na = act;
        case (st)
            pavs_pkg::ST_ATTACK: begin
                if (att >= {1'b0, pavs_pkg::LEVEL_ONE}) begin
                    nl = pavs_pkg::LEVEL_ONE;
                    ns = pavs_pkg::ST_DECAY;
                end else begin
                    nl = att[pavs_pkg::LEVEL_W-1:0];
                end
            end
            pavs_pkg::ST_DECAY: begin
                if (dec <= i_cfg.hold_level) begin
                    nl = i_cfg.hold_level;
                    ns = pavs_pkg::ST_SUSTAIN;
                end else begin
                    nl = dec;
                end
            end
            pavs_pkg::ST_SUSTAIN: nl = i_cfg.hold_level;
            pavs_pkg::ST_RELEASE: begin
                if (lv <= i_cfg.release_step) begin
                    nl = '0;
                    ns = pavs_pkg::ST_IDLE;
                    na = 1'b0;
                end else begin
                    nl = lv - i_cfg.release_step;
                end
            end
            default: begin
                nl = '0;
                na = 1'b0;
            end
        endcase
    end

    // voice term and final scaling
    assign prod   = (PROD_W_L'(r_phi) <<< 17) + PROD_W_L'(r_plo);
    assign term   = (prod + PROD_W_L'(32768)) >>> 16;
    assign scaled = (64'(r_mix) <<< 15) - 64'(r_mix);
    assign s      = 32'((scaled + 64'sd2147483648) >>> 32);

    always_comb begin
        clip = 1'b0;
        sat  = s[15:0];
        if (s > 32'sd32767) begin
            sat  = 16'h7fff;
            clip = 1'b1;
        end else if (s < -32'sd32768) begin
            sat  = 16'h8000;
            clip = 1'b1;
        end
    end

    always_comb begin
        if (r_i_found) begin
            pick = r_i_idx;
        end else if (r_r_found) begin
            pick = r_r_idx;
        end else begin
            pick = '0;
        end
    end

    assign out_free = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pavs_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_item.op)
                        pavs_pkg::OP_TICK:    n_state = pavs_pkg::B_ENV;
                        pavs_pkg::OP_ALL_OFF: n_state = pavs_pkg::B_IDLE;
                        default:              n_state = pavs_pkg::B_SCAN;
                    endcase
                end
            end
            pavs_pkg::B_SCAN:  n_state = last_v ? pavs_pkg::B_APPLY : pavs_pkg::B_SCAN;
            pavs_pkg::B_APPLY: n_state = pavs_pkg::B_IDLE;
            pavs_pkg::B_ENV: begin
                if (!skip) begin
                    n_state = pavs_pkg::B_GAIN;
                end else if (last_v) begin
                    n_state = pavs_pkg::B_ROUND;
                end
            end
            pavs_pkg::B_GAIN:  n_state = pavs_pkg::B_HARM;
            pavs_pkg::B_HARM:  n_state = (r_h == 3'(pavs_pkg::HARM_COUNT)) ?
                                         pavs_pkg::B_MUL : pavs_pkg::B_HARM;
            pavs_pkg::B_MUL:   n_state = pavs_pkg::B_TERM;
            pavs_pkg::B_TERM:  n_state = last_v ? pavs_pkg::B_ROUND : pavs_pkg::B_ENV;
            pavs_pkg::B_ROUND: n_state = out_free ? pavs_pkg::B_IDLE : pavs_pkg::B_ROUND;
            default:           n_state = pavs_pkg::B_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_q_pop = (r_state == pavs_pkg::B_IDLE) && i_q_valid;
    end

    assign o_valid   = r_out_valid;
    assign o_sample  = r_out_sample;
    assign o_clipped = r_out_clip;

    // sine rom, registered read
    always_ff @(posedge i_clk) begin
        r_sin <= SINE[r_hp[PHASE_BITS-1 -: SINE_TABLE_BITS]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pavs_pkg::B_IDLE;
            r_out_valid <= 1'b0;
            for (int v = 0; v < VOICE_COUNT; v++) begin
                r_active[v] <= 1'b0;
                r_stage[v]  <= pavs_pkg::ST_IDLE;
            end
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_ready && (r_state != pavs_pkg::B_ROUND)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                pavs_pkg::B_IDLE: begin
                    r_v       <= '0;
                    r_mix     <= '0;
                    r_m_found <= 1'b0;
                    r_i_found <= 1'b0;
                    r_r_found <= 1'b0;
                    r_item    <= i_q_item;
                    if (i_q_valid && i_q_item.op == pavs_pkg::OP_ALL_OFF) begin
                        for (int v = 0; v < VOICE_COUNT; v++) begin
                            if (r_active[v]) begin
                                r_stage[v] <= pavs_pkg::ST_RELEASE;
                            end
                        end
                    end
                end
                pavs_pkg::B_SCAN: begin
                    if (!r_m_found && act && r_note[r_v] == r_item.note) begin
                        r_m_found <= 1'b1;
                        r_m_idx   <= r_v;
                    end
                    if (!r_i_found && skip) begin
                        r_i_found <= 1'b1;
                        r_i_idx   <= r_v;
                    end
                    if (!r_r_found && st == pavs_pkg::ST_RELEASE) begin
                        r_r_found <= 1'b1;
                        r_r_idx   <= r_v;
                    end
                    r_v <= r_v + VW'(1);
                end
                pavs_pkg::B_APPLY: begin
                    if (r_item.op == pavs_pkg::OP_NOTE_OFF) begin
                        if (r_m_found) begin
                            r_stage[r_m_idx] <= pavs_pkg::ST_RELEASE;
                        end
                    end else if (!r_m_found) begin
                        r_note[pick]   <= r_item.note;
                        r_inc[pick]    <= PITCH[r_item.note];
                        r_phase[pick]  <= '0;
                        r_active[pick] <= 1'b1;
                        r_stage[pick]  <= pavs_pkg::ST_ATTACK;
                        r_level[pick]  <= '0;
                    end
                end
                pavs_pkg::B_ENV: begin
                    if (skip) begin
                        r_v <= r_v + VW'(1);
                    end else begin
                        r_level[r_v]  <= nl;
                        r_stage[r_v]  <= ns;
                        r_active[r_v] <= na;
                    end
                end
                pavs_pkg::B_GAIN: begin
                    r_gain <= 17'((40'(i_cfg.note_amplitude) * 40'(lv)) >> 23);
                    r_hp   <= r_phase[r_v];
                    r_h    <= '0;
                    r_acc  <= '0;
                end
                pavs_pkg::B_HARM: begin
                    r_hp <= r_hp + r_phase[r_v];
                    r_h  <= r_h + 3'd1;
                    if (r_h != 3'd0) begin
                        r_acc <= r_acc + pavs_pkg::ACC_W'(r_sin *
                                 $signed({1'b0, pavs_pkg::f_weight(r_h - 3'd1)}));
                    end
                end
                pavs_pkg::B_MUL: begin
                    r_plo <= $signed({1'b0, r_acc[16:0]}) * $signed({1'b0, r_gain});
                    r_phi <= $signed(r_acc[pavs_pkg::ACC_W-1:17]) * $signed({1'b0, r_gain});
                end
                pavs_pkg::B_TERM: begin
                    r_mix        <= r_mix + pavs_pkg::MIX_W'(term);
                    r_phase[r_v] <= r_phase[r_v] + r_inc[r_v];
                    r_v          <= r_v + VW'(1);
                end
                pavs_pkg::B_ROUND: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_sample <= sat;
                        r_out_clip   <= clip;
                    end
                end
                default: begin
                    r_v <= '0;
                end
            endcase
        end
    end

endmodule

[hw/rtl/polyphonic_additive_voice_synth_top.sv]
// top level of the polyphonic additive voice synthesiser
// Commands arrive one per transfer on the slave stream: tuser carries the opcode
// (sample tick, note on, note off, all notes off) and tdata the MIDI note. Only a
// sample tick gives a result: one transfer on the master stream with the 16-bit
// mixed sample in tdata and the saturation flag in tuser. A two-entry queue sits
// between the input and the voice sequencer, so commands are taken while the
// sequencer works and while a finished sample waits to be taken, as long as the
// queue has room. The sequencer handles one command at a time and is the rate limit.
// A note on or note off scans the voice table one voice a cycle. All notes off puts
// every active voice into release without a scan. A sample tick steps past each
// silent voice and, for each sounding voice, runs the envelope step, the gain
// multiply, five harmonics through the registered sine rom read, the voice product
// in two halves and the mix add. Configuration writes take effect at once and are
// meant to be made while no command is in flight.
module polyphonic_additive_voice_synth_top #(
    parameter int VOICE_COUNT     = 8,
    parameter int SINE_TABLE_BITS = 10,
    parameter int SAMPLE_RATE_HZ  = 48000,
    parameter int PHASE_BITS      = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [6:0] note, [7] zero
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] opcode
    // sample stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] sample_out
    output logic [0:0]  o_m_axis_tuser,   // [0] clipped
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    pavs_pkg::t_cfg  r_cfg;
    logic            q_valid;
    pavs_pkg::t_item q_item;
    logic            q_pop;
    logic            clipped;

    // register file, always ready; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.attack_step    <= 24'd17476;
            r_cfg.decay_step     <= 24'd524;
            r_cfg.release_step   <= 24'd408;
            r_cfg.hold_level     <= 24'd5872026;
            r_cfg.note_amplitude <= 16'd19661;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pavs_pkg::CFG_ATTACK:  r_cfg.attack_step    <= i_cfg_data;
                pavs_pkg::CFG_DECAY:   r_cfg.decay_step     <= i_cfg_data;
                pavs_pkg::CFG_RELEASE: r_cfg.release_step   <= i_cfg_data;
                pavs_pkg::CFG_SUSTAIN: r_cfg.hold_level     <= i_cfg_data;
                pavs_pkg::CFG_AMP:     r_cfg.note_amplitude <= i_cfg_data[15:0];
                default:               r_cfg <= r_cfg;
            endcase
        end
    end

    // front end: accept and queue commands
    pavs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_opcode  (i_s_axis_tuser),
        .i_note    (i_s_axis_tdata[6:0]),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    // back end: voices, envelopes, harmonics and mix
    pavs_back #(
        .VOICE_COUNT     (VOICE_COUNT),
        .SINE_TABLE_BITS (SINE_TABLE_BITS),
        .SAMPLE_RATE_HZ  (SAMPLE_RATE_HZ),
        .PHASE_BITS      (PHASE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_sample  (o_m_axis_tdata),
        .o_clipped (clipped)
    );

    assign o_m_axis_tuser = clipped;

endmodule

[hw/rtl/pavs_checker.sv]
// port-level checks for the synthesiser top level
module pavs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [15:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);

    // a waiting sample is not withdrawn
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("sample withdrawn before transfer");

    // reset leaves no sample pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("sample pending after reset");

    // a clipped sample sits on a rail
    a_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            (o_m_axis_tdata == 16'h7fff) || (o_m_axis_tdata == 16'h8000))
        else $error("clip flag without saturated sample");

endmodule

bind polyphonic_additive_voice_synth_top pavs_checker u_pavs_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);
